// File: hw/rtl/mixed_font_glyph_row_fetcher_top_defines.svh
// ----------------------------------------------------------------------------
// Glyph row fetcher assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MIXED_FONT_GLYPH_ROW_FETCHER_TOP_DEFINES_SVH
`define MIXED_FONT_GLYPH_ROW_FETCHER_TOP_DEFINES_SVH

`ifndef SYNTH
// Property checked on every edge outside reset
`define MFGR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("glyph row fetcher check failed");
// Expression that must never be true outside reset
`define MFGR_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("glyph row fetcher forbidden condition");
`else
`define MFGR_ASSERT(lbl, prop)
`define MFGR_NEVER(lbl, expr)
`endif

`endif

// File: hw/rtl/mfgr_pkg.sv
// ----------------------------------------------------------------------------
// Glyph row fetcher package
// Beat types, operation codes and sizes shared by the fetcher modules.
// ----------------------------------------------------------------------------
package mfgr_pkg;

  // Row buffer size in bytes
  localparam int LINE_BYTES = 48;

  // Queue depths
  localparam int OPQ_DEPTH  = 2;
  localparam int OUTQ_DEPTH = 4;

  // Register reset values
  localparam logic [23:0] FONT_BASE_RST = 24'h0B0000;
  localparam logic [23:0] HANZI_OFF_RST = 24'h001806;

  // GB2312 row/column origin
  localparam logic [7:0] GB_ORIGIN = 8'hA1;

  // Line end pair
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // ASCII single-byte range (space to DEL)
  localparam logic [7:0] ASCII_LO = 8'd32;
  localparam logic [7:0] ASCII_HI = 8'd127;

  // Configuration register indexes
  localparam logic CFG_FONT_BASE = 1'b0;
  localparam logic CFG_HANZI_OFF = 1'b1;

  // Result kinds
  typedef enum logic [2:0] {
    RK_ASCII    = 3'd0,
    RK_HANZI    = 3'd1,
    RK_LINE_END = 3'd2,
    RK_CODE_ERR = 3'd3,
    RK_OVERFLOW = 3'd4
  } result_kind_t;

  // Operations handed from front to back
  typedef enum logic [1:0] {
    OP_ASCII    = 2'd0,
    OP_HANZI    = 2'd1,
    OP_LINE_END = 2'd2,
    OP_CODE_ERR = 2'd3
  } op_kind_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic [4:0] glyph_row;
  } in_beat_t;

  typedef struct packed {
    result_kind_t result_kind;
    logic [23:0]  flash_address;
    logic [1:0]   fetch_length;
    logic [5:0]   line_offset;
    logic         line_last;
  } out_beat_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] byte_a;   // ASCII code or lead byte
    logic [7:0] byte_b;   // trail byte
    logic [4:0] row;
  } op_t;

endpackage

// File: hw/rtl/mfgr_front.sv
// ----------------------------------------------------------------------------
// Glyph row fetcher front end
// Pairs lead and trail bytes and classifies each character into an op.
// ----------------------------------------------------------------------------
module mfgr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  mfgr_pkg::in_beat_t in_data,
  output logic              op_valid,
  output mfgr_pkg::op_t     op
);

  logic       lead_pend_r, lead_pend_nxt;
  logic [7:0] lead_byte_r, lead_byte_nxt;
  logic       is_ascii;

  assign is_ascii = (in_data.text_byte >= mfgr_pkg::ASCII_LO) &&
                    (in_data.text_byte <= mfgr_pkg::ASCII_HI);

  // Classification
  always_comb begin
    lead_pend_nxt = lead_pend_r;
    lead_byte_nxt = lead_byte_r;
    op_valid      = 1'b0;
    op.byte_a     = in_data.text_byte;
    op.byte_b     = in_data.text_byte;
    op.row        = in_data.glyph_row;
    op.kind       = mfgr_pkg::OP_ASCII;
    if (accept) begin
      if (lead_pend_r) begin
        lead_pend_nxt = 1'b0;
        op_valid      = 1'b1;
        op.byte_a     = lead_byte_r;
        if (lead_byte_r == mfgr_pkg::CHAR_CR && in_data.text_byte == mfgr_pkg::CHAR_LF) begin
          op.kind = mfgr_pkg::OP_LINE_END;
        end else if (lead_byte_r < mfgr_pkg::GB_ORIGIN ||
                     in_data.text_byte < mfgr_pkg::GB_ORIGIN) begin
          op.kind = mfgr_pkg::OP_CODE_ERR;
        end else begin
          op.kind = mfgr_pkg::OP_HANZI;
        end
      end else if (is_ascii) begin
        op_valid = 1'b1;
      end else begin
        lead_pend_nxt = 1'b1;
        lead_byte_nxt = in_data.text_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_pend_r <= 1'b0;
      lead_byte_r <= '0;
    end else begin
      lead_pend_r <= lead_pend_nxt;
      lead_byte_r <= lead_byte_nxt;
    end
  end

endmodule

// File: hw/rtl/mfgr_opq.sv
// ----------------------------------------------------------------------------
// Glyph row fetcher op queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module mfgr_opq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  mfgr_pkg::op_t wr_op,
  input  logic          rd_en,
  output mfgr_pkg::op_t rd_op,
  output logic          q_full,
  output logic          q_empty
);

  localparam int PW = (mfgr_pkg::OPQ_DEPTH > 1) ? $clog2(mfgr_pkg::OPQ_DEPTH) : 1;
  localparam int CW = $clog2(mfgr_pkg::OPQ_DEPTH + 1);

  mfgr_pkg::op_t mem_r [mfgr_pkg::OPQ_DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign q_full  = (cnt_r == CW'(mfgr_pkg::OPQ_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_op   = mem_r[rptr_r];

  // Pointer and count update
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == PW'(mfgr_pkg::OPQ_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == PW'(mfgr_pkg::OPQ_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(do_wr) - CW'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_op;
    end
  end

endmodule

// File: hw/rtl/mfgr_back.sv
// ----------------------------------------------------------------------------
// Glyph row fetcher back end
// Tracks the row buffer column, builds font addresses and queues results.
// ----------------------------------------------------------------------------
`include "mixed_font_glyph_row_fetcher_top_defines.svh"

module mfgr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [23:0]         cfg_wdata,
  input  logic                q_empty,
  input  mfgr_pkg::op_t       q_op,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output mfgr_pkg::out_beat_t out_data
);

  localparam int OPW = $clog2(mfgr_pkg::OUTQ_DEPTH);
  localparam int OCW = $clog2(mfgr_pkg::OUTQ_DEPTH + 1);

  // Configuration
  logic [23:0] font_base_r, hanzi_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      font_base_r <= mfgr_pkg::FONT_BASE_RST;
      hanzi_off_r <= mfgr_pkg::HANZI_OFF_RST;
    end else if (cfg_we) begin
      if (cfg_index == mfgr_pkg::CFG_FONT_BASE) font_base_r <= cfg_wdata;
      if (cfg_index == mfgr_pkg::CFG_HANZI_OFF) hanzi_off_r <= cfg_wdata;
    end
  end

  // Output queue state
  mfgr_pkg::out_beat_t oq_r [mfgr_pkg::OUTQ_DEPTH];
  logic [OPW-1:0] owp_r, orp_r;
  logic [OCW-1:0] ocnt_r, ocnt_nxt;
  logic           o_wr, o_rd;

  // Stage 1 registers
  logic                   s1_valid_r;
  mfgr_pkg::result_kind_t s1_kind_r, s1_kind_nxt;
  logic [1:0]             s1_len_r, s1_len_nxt;
  logic [5:0]             s1_off_r;
  logic                   s1_last_r, s1_last_nxt;
  logic                   s1_hz_r;
  logic [13:0]            s1_prod_r, s1_prod_nxt;
  logic [4:0]             s1_row_r;
  logic [5:0]             col_r, col_nxt;

  // Space check counts the beat already in stage 1
  assign q_pop = !q_empty &&
                 ((ocnt_r + OCW'(s1_valid_r)) < OCW'(mfgr_pkg::OUTQ_DEPTH));

  // Stage 1: column bookkeeping and glyph index
  logic [1:0]  op_len;
  logic [6:0]  col_sum;
  logic        ovf;
  logic [6:0]  lead_idx, trail_idx;

  always_comb begin
    op_len    = (q_op.kind == mfgr_pkg::OP_HANZI) ? 2'd3 : 2'd2;
    col_sum   = {1'b0, col_r} + 7'(op_len);
    ovf       = col_sum > 7'(mfgr_pkg::LINE_BYTES);
    lead_idx  = 7'(q_op.byte_a - mfgr_pkg::GB_ORIGIN);
    trail_idx = 7'(q_op.byte_b - mfgr_pkg::GB_ORIGIN);
    col_nxt     = col_r;
    s1_len_nxt  = 2'd0;
    s1_last_nxt = 1'b0;
    s1_kind_nxt = mfgr_pkg::RK_CODE_ERR;
    s1_prod_nxt = 14'(q_op.byte_a) * 14'(48);
    unique case (q_op.kind)
      mfgr_pkg::OP_ASCII, mfgr_pkg::OP_HANZI: begin
        if (q_op.kind == mfgr_pkg::OP_HANZI) begin
          s1_prod_nxt = 14'(lead_idx) * 14'(94) + 14'(trail_idx);
        end
        if (ovf) begin
          s1_kind_nxt = mfgr_pkg::RK_OVERFLOW;
        end else begin
          s1_kind_nxt = (q_op.kind == mfgr_pkg::OP_HANZI) ? mfgr_pkg::RK_HANZI
                                                           : mfgr_pkg::RK_ASCII;
          s1_len_nxt  = op_len;
          col_nxt     = col_sum[5:0];
        end
      end
      mfgr_pkg::OP_LINE_END: begin
        s1_kind_nxt = mfgr_pkg::RK_LINE_END;
        s1_last_nxt = 1'b1;
        col_nxt     = '0;
      end
      mfgr_pkg::OP_CODE_ERR: begin
        s1_kind_nxt = mfgr_pkg::RK_CODE_ERR;
      end
      default: begin
        s1_kind_nxt = mfgr_pkg::RK_CODE_ERR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      col_r      <= '0;
    end else begin
      s1_valid_r <= q_pop;
      if (q_pop) col_r <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_kind_r <= s1_kind_nxt;
      s1_len_r  <= s1_len_nxt;
      s1_off_r  <= col_r;
      s1_last_r <= s1_last_nxt;
      s1_hz_r   <= (q_op.kind == mfgr_pkg::OP_HANZI);
      s1_prod_r <= s1_prod_nxt;
      s1_row_r  <= q_op.row;
    end
  end

  // Stage 2: flash address
  mfgr_pkg::out_beat_t s2_beat;
  logic [23:0]         addr;

  always_comb begin
    if (s1_hz_r) begin
      addr = font_base_r + hanzi_off_r + 24'(s1_prod_r) * 24'(72)
           + 24'(s1_row_r) * 24'(3);
    end else begin
      addr = font_base_r + 24'(s1_prod_r) + 24'({s1_row_r, 1'b0});
    end
    s2_beat.result_kind   = s1_kind_r;
    s2_beat.flash_address = (s1_len_r != 2'd0) ? addr : 24'd0;
    s2_beat.fetch_length  = s1_len_r;
    s2_beat.line_offset   = s1_off_r;
    s2_beat.line_last     = s1_last_r;
  end

  // Output queue
  assign o_wr     = s1_valid_r;
  assign o_rd     = pop && !empty;
  assign empty    = (ocnt_r == '0);
  assign out_data = oq_r[orp_r];
  assign ocnt_nxt = ocnt_r + OCW'(o_wr) - OCW'(o_rd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (o_wr) owp_r <= owp_r + 1'b1;
      if (o_rd) orp_r <= orp_r + 1'b1;
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (o_wr) begin
      oq_r[owp_r] <= s2_beat;
    end
  end

  // Checks
  `MFGR_NEVER(a_oq_overrun, (ocnt_r + OCW'(s1_valid_r)) > OCW'(mfgr_pkg::OUTQ_DEPTH))
  `MFGR_NEVER(a_col_range, col_r > 6'(mfgr_pkg::LINE_BYTES))
  `MFGR_ASSERT(a_pop_fills_s1, q_pop |=> s1_valid_r)
  `MFGR_ASSERT(a_len_kind, s1_valid_r && s1_len_r != 2'd0 |->
               (s1_kind_r == mfgr_pkg::RK_ASCII || s1_kind_r == mfgr_pkg::RK_HANZI))

endmodule

// File: hw/rtl/mixed_font_glyph_row_fetcher_top.sv
// ----------------------------------------------------------------------------
// Mixed font glyph row fetcher
// Turns a text byte stream into font memory read requests for one dot row.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive in_data (text byte + glyph row) with push; a beat is
//   taken on a clock edge with push high and full low.
//   Result queue: out_data holds the oldest result while empty is low; pop
//   takes it. Each text byte gives at most one result; a lead byte gives none.
//   Config: cfg_we writes cfg_wdata into register cfg_index (0 font base,
//   1 GB2312 table offset) on the same edge; write only while idle.
// Timing:
//   One byte per cycle while full is low. A taken byte's result passes
//   through the op queue and the column stage into the 4-entry result queue.
// Reset: synchronous, active low. Clears the pending lead, the column, both
//   queues, and loads the default register values.
// Stall:
//   When pop stays low the result queue fills, the back end stops draining
//   the 2-entry op queue, and full rises until results are taken.
// ----------------------------------------------------------------------------
module mixed_font_glyph_row_fetcher_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  mfgr_pkg::in_beat_t  in_data,
  output logic                empty,
  input  logic                pop,
  output mfgr_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [23:0]         cfg_wdata
);

  logic          accept;
  logic          op_valid;
  mfgr_pkg::op_t fe_op;
  mfgr_pkg::op_t q_op;
  logic          q_empty;
  logic          q_pop;

  assign accept = push && !full;

  // Front end
  mfgr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_data  (in_data),
    .op_valid (op_valid),
    .op       (fe_op)
  );

  // Op queue
  mfgr_opq u_opq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (op_valid),
    .wr_op   (fe_op),
    .rd_en   (q_pop),
    .rd_op   (q_op),
    .q_full  (full),
    .q_empty (q_empty)
  );

  // Back end
  mfgr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_empty   (q_empty),
    .q_op      (q_op),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .out_data  (out_data)
  );

endmodule

// File: test/mixed_font_glyph_row_fetcher_top_tb.sv
// ----------------------------------------------------------------------------
// Glyph row fetcher testbench
// Streams text lines (ASCII, GB2312 pairs, malformed pairs, CR LF) into the
// fetcher and checks every read request against a local model of the row
// address math, the column count and the overflow rule. Both the sender and
// the receiver idle at random, and the font registers change between phases.
// ----------------------------------------------------------------------------
module mixed_font_glyph_row_fetcher_top_tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RESULT_DELAY = 8;
  localparam int LONG_HOLD    = 300;
  localparam int TARGET_BEATS = 1350;

  // Receiver pop patterns
  localparam int POP_ALWAYS   = 0;
  localparam int POP_HALF     = 1;
  localparam int POP_SPARSE   = 2;
  localparam int POP_PERIODIC = 3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                push = 1'b0;
  logic                full;
  mfgr_pkg::in_beat_t  in_data = '0;
  logic                empty;
  logic                pop = 1'b0;
  mfgr_pkg::out_beat_t out_data;
  logic                cfg_we = 1'b0;
  logic                cfg_index = mfgr_pkg::CFG_FONT_BASE;
  logic [23:0]         cfg_wdata = '0;

  // Model state of the fetcher
  logic [23:0] font_base = mfgr_pkg::FONT_BASE_RST;
  logic [23:0] hanzi_off = mfgr_pkg::HANZI_OFF_RST;
  logic        lead_held = 1'b0;
  logic [7:0]  held_lead = '0;
  logic [5:0]  column = '0;

  mfgr_pkg::out_beat_t pending_fetches[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          beats_sent = 0;
  int          burst_left = 0;
  bit          sender_gaps = 1'b1;
  logic        hold_toggle = 1'b0;

  mixed_font_glyph_row_fetcher_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Fetch or overflow, depending on room left in the row buffer
  function automatic void queue_fetch(mfgr_pkg::result_kind_t kind, logic [23:0] addr,
                                      logic [1:0] len);
    mfgr_pkg::out_beat_t r;
    r = '0;
    r.line_offset = column;
    if (32'(column) + 32'(len) > mfgr_pkg::LINE_BYTES) begin
      r.result_kind = mfgr_pkg::RK_OVERFLOW;
    end else begin
      r.result_kind   = kind;
      r.flash_address = addr;
      r.fetch_length  = len;
      column          = column + 6'(len);
    end
    pending_fetches.push_back(r);
  endfunction

  // Row fetch prediction for one accepted text byte
  function automatic void predict_row_fetch(mfgr_pkg::in_beat_t b);
    mfgr_pkg::out_beat_t r;
    logic [31:0]         addr;
    r = '0;
    if (lead_held) begin
      lead_held = 1'b0;
      if (held_lead == mfgr_pkg::CHAR_CR && b.text_byte == mfgr_pkg::CHAR_LF) begin
        r.result_kind = mfgr_pkg::RK_LINE_END;
        r.line_offset = column;
        r.line_last   = 1'b1;
        column        = '0;
        pending_fetches.push_back(r);
      end else if (held_lead < mfgr_pkg::GB_ORIGIN || b.text_byte < mfgr_pkg::GB_ORIGIN) begin
        r.result_kind = mfgr_pkg::RK_CODE_ERR;
        r.line_offset = column;
        pending_fetches.push_back(r);
      end else begin
        addr = 32'(font_base) + 32'(hanzi_off)
             + ((32'(held_lead) - 32'(mfgr_pkg::GB_ORIGIN)) * 94
                + (32'(b.text_byte) - 32'(mfgr_pkg::GB_ORIGIN))) * 72
             + 32'(b.glyph_row) * 3;
        queue_fetch(mfgr_pkg::RK_HANZI, addr[23:0], 2'd3);
      end
    end else if (b.text_byte >= mfgr_pkg::ASCII_LO && b.text_byte <= mfgr_pkg::ASCII_HI) begin
      addr = 32'(font_base) + 32'(b.text_byte) * 48 + 32'(b.glyph_row) * 2;
      queue_fetch(mfgr_pkg::RK_ASCII, addr[23:0], 2'd2);
    end else begin
      held_lead = b.text_byte;
      lead_held = 1'b1;
    end
  endfunction

  // Receiver: own stall pattern, plus a long hold on request
  always @(posedge clk) begin : receiver
    static int  recv_cycle = 0;
    static int  recv_mode = POP_ALWAYS;
    static int  hold_left = 0;
    static bit  hold_seen = 1'b0;
    recv_cycle++;
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = LONG_HOLD;
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      if (recv_cycle % 64 == 0) recv_mode = $urandom_range(POP_ALWAYS, POP_PERIODIC);
      case (recv_mode)
        POP_ALWAYS:   pop <= 1'b1;
        POP_HALF:     pop <= 1'($urandom_range(0, 1));
        POP_SPARSE:   pop <= ($urandom_range(0, 3) == 0);
        default:      pop <= (recv_cycle % 3 != 0);
      endcase
    end
  end

  task automatic check_field(input string field, input logic [23:0] want,
                             input logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      fail_count++;
    end
  endtask

  // Result checker: one beat per pop edge
  always @(posedge clk) begin : result_check
    mfgr_pkg::out_beat_t want;
    if (rst_n && pop && !empty) begin
      if (pending_fetches.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, out_data);
        fail_count++;
      end else begin
        want = pending_fetches.pop_front();
        check_field("result_kind", 24'(want.result_kind), 24'(out_data.result_kind));
        check_field("flash_address", want.flash_address, out_data.flash_address);
        check_field("fetch_length", 24'(want.fetch_length), 24'(out_data.fetch_length));
        check_field("line_offset", 24'(want.line_offset), 24'(out_data.line_offset));
        check_field("line_last", 24'(want.line_last), 24'(out_data.line_last));
      end
    end
  end

  // Send one text byte; bursts with random gaps in between
  task automatic send_text_beat(input logic [7:0] code, input logic [4:0] row);
    mfgr_pkg::in_beat_t beat;
    int                 gap;
    beat.text_byte = code;
    beat.glyph_row = row;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = sender_gaps ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_data <= beat;
    push    <= 1'b1;
    do @(posedge clk); while (full);
    predict_row_fetch(beat);
    beats_sent++;
  endtask

  // Stop sending and let every expected result come out
  task automatic drain_results();
    push <= 1'b0;
    burst_left = 0;
    while (pending_fetches.size() != 0) @(posedge clk);
    repeat (RESULT_DELAY) @(posedge clk);
  endtask

  task automatic write_font_reg(input logic idx, input logic [23:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == mfgr_pkg::CFG_FONT_BASE) font_base = value;
    else hanzi_off = value;
  endtask

  task automatic configure_font(input logic [23:0] base, input logic [23:0] off);
    drain_results();
    write_font_reg(mfgr_pkg::CFG_FONT_BASE, base);
    write_font_reg(mfgr_pkg::CFG_HANZI_OFF, off);
  endtask

  task automatic send_pair(input logic [7:0] lead, input logic [7:0] trail,
                           input logic [4:0] row);
    send_text_beat(lead, row);
    send_text_beat(trail, row);
  endtask

  // One text line of random characters, optionally closed by CR LF
  task automatic send_text_line(input int n_chars, input bit terminate);
    logic [4:0] row;
    logic [7:0] lead;
    int         pick;
    row = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31))
                                      : 5'($urandom_range(0, 23));
    for (int i = 0; i < n_chars; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_text_beat(8'($urandom_range(mfgr_pkg::ASCII_LO, mfgr_pkg::ASCII_HI)), row);
      end else if (pick < 85) begin
        send_pair(8'($urandom_range(mfgr_pkg::GB_ORIGIN, 8'hFF)),
                  8'($urandom_range(mfgr_pkg::GB_ORIGIN, 8'hFF)), row);
      end else begin
        // pair that may be malformed: stray CR or any non-ASCII lead, any trail
        lead = 8'($urandom_range(0, 159));
        if (lead >= mfgr_pkg::ASCII_LO) lead = lead + 8'd96;
        if (pick < 90) lead = mfgr_pkg::CHAR_CR;
        send_pair(lead, 8'($urandom()), row);
      end
    end
    if (terminate) send_pair(mfgr_pkg::CHAR_CR, mfgr_pkg::CHAR_LF, row);
  endtask

  // Character classes and their corner codes at the reset register values
  task automatic test_char_classes();
    send_text_beat(mfgr_pkg::ASCII_LO, 5'd0);
    send_text_beat(mfgr_pkg::ASCII_HI, 5'd23);
    send_text_beat(8'h55, 5'd31);
    send_pair(mfgr_pkg::GB_ORIGIN, mfgr_pkg::GB_ORIGIN, 5'd0);
    send_pair(8'hF7, 8'hFE, 5'd23);
    send_pair(8'hFF, 8'hFF, 5'd31);
    send_pair(8'h80, 8'hB0, 5'd5);
    send_pair(8'hB0, 8'h41, 5'd6);
    send_pair(mfgr_pkg::CHAR_CR, 8'h41, 5'd7);
    send_pair(8'h00, 8'hFF, 5'd8);
    send_pair(8'h1F, mfgr_pkg::GB_ORIGIN, 5'd9);
    send_pair(mfgr_pkg::CHAR_CR, mfgr_pkg::CHAR_LF, 5'd10);
  endtask

  // Register extremes and a random setting
  task automatic test_register_extremes();
    configure_font(24'h000000, 24'h000000);
    send_text_line(8, 1'b1);
    configure_font(24'hFFFFFF, 24'hFFFFFF);
    send_text_line(8, 1'b1);
    configure_font(24'($urandom()), 24'($urandom()));
    send_text_line(8, 1'b1);
    configure_font(24'hFFFFFF, 24'h000000);
    send_text_line(8, 1'b1);
  endtask

  // Fill the row buffer to its last bytes and run past it
  task automatic test_line_overflow();
    send_pair(mfgr_pkg::CHAR_CR, mfgr_pkg::CHAR_LF, 5'd3);
    for (int i = 0; i < 23; i++) send_text_beat(8'(8'd65 + i), 5'd3);
    send_pair(8'hB0, mfgr_pkg::GB_ORIGIN, 5'd3);
    send_text_beat(8'h7A, 5'd3);
    send_text_beat(8'h7B, 5'd3);
    send_pair(8'hC0, 8'hC1, 5'd3);
    send_pair(mfgr_pkg::CHAR_CR, mfgr_pkg::CHAR_LF, 5'd3);
    send_pair(mfgr_pkg::CHAR_CR, mfgr_pkg::CHAR_LF, 5'd3);
  endtask

  // Receiver holds off while the sender keeps offering beats
  task automatic test_backpressure();
    drain_results();
    sender_gaps = 1'b0;
    hold_toggle <= ~hold_toggle;
    send_text_line(20, 1'b1);
    send_text_line(20, 1'b1);
    drain_results();
    sender_gaps = 1'b1;
  endtask

  // Random lines with register changes between phases
  task automatic test_random_lines();
    int          lines;
    int          n_chars;
    logic [23:0] base;
    logic [23:0] off;
    lines = 0;
    while (beats_sent < TARGET_BEATS) begin
      sender_gaps = ($urandom_range(0, 3) != 0);
      n_chars = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 20);
      send_text_line(n_chars, $urandom_range(0, 9) != 0);
      lines++;
      if (lines % 25 == 0) begin
        case ($urandom_range(0, 3))
          0: begin base = 24'h000000; off = 24'hFFFFFF; end
          1: begin base = mfgr_pkg::FONT_BASE_RST; off = mfgr_pkg::HANZI_OFF_RST; end
          2: begin base = 24'hFFFFFF; off = 24'($urandom()); end
          default: begin base = 24'($urandom()); off = 24'($urandom()); end
        endcase
        configure_font(base, off);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_char_classes();
    test_register_extremes();
    test_line_overflow();
    test_backpressure();
    test_random_lines();
    drain_results();
    if (fail_count == 0 && pending_fetches.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
